// ===== src/nsta_pkg.sv =====
// shared types and constants for the nested scope time accumulator
`default_nettype none
package nsta_pkg;
    localparam int ANCHOR_COUNT = 4096;
    localparam int STACK_DEPTH  = 64;
    localparam int AW  = $clog2(ANCHOR_COUNT);
    localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW  = $clog2(STACK_DEPTH + 1);
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ENTER = 2'd0,
        KIND_EXIT  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD_A,
        B_RD_B,
        B_WR_A,
        B_WR_B,
        B_OUT
    } bstate_t;

    // classified command from front to back
    typedef struct packed {
        kind_t          kind;
        logic           ok;
        logic [AW-1:0]  anchor;
        logic [AW-1:0]  parent;
        logic [SW-1:0]  slot;
        logic [63:0]    stamp;
    } cmd_t;
endpackage
`default_nettype wire

// ===== src/nsta_front.sv =====
// front end: takes beats, keeps stack level and parent, classifies
`default_nettype none
module nsta_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_kind,
    input  wire logic [11:0]      in_anchor,
    input  wire logic [63:0]      in_stamp,
    input  wire logic             busy,
    input  wire logic             pop_done,
    input  wire logic [nsta_pkg::AW-1:0] pop_parent,
    output nsta_pkg::cmd_t        q_data,
    output logic                  q_push,
    input  wire logic             q_full
);
    logic [nsta_pkg::LW-1:0] level_reg, level_next;
    logic [nsta_pkg::AW-1:0] parent_reg, parent_next;
    logic                    pend_reg, pend_next;
    logic [nsta_pkg::AW-1:0] idx;

    // an exit restores parent only after back pops; hold until then
    assign in_ready = !q_full && !pend_reg && !busy;
    assign q_push   = in_valid && in_ready;
    assign idx      = nsta_pkg::AW'(in_anchor % nsta_pkg::ANCHOR_COUNT);

    always_comb begin
        q_data        = '0;
        q_data.kind   = nsta_pkg::kind_t'(in_kind);
        q_data.anchor = idx;
        q_data.parent = parent_reg;
        q_data.stamp  = in_stamp;
        q_data.ok     = 1'b1;
        level_next    = level_reg;
        parent_next   = parent_reg;
        pend_next     = pend_reg;
        if (pend_reg && pop_done) begin
            pend_next   = 1'b0;
            parent_next = pop_parent;
        end
        if (q_push) begin
            unique case (nsta_pkg::kind_t'(in_kind))
                nsta_pkg::KIND_ENTER: begin
                    q_data.slot = nsta_pkg::SW'(level_reg);
                    if (level_reg == nsta_pkg::LW'(nsta_pkg::STACK_DEPTH)) begin
                        q_data.ok = 1'b0;
                    end else begin
                        level_next  = level_reg + 1'b1;
                        parent_next = idx;
                    end
                end
                nsta_pkg::KIND_EXIT: begin
                    q_data.slot = nsta_pkg::SW'(level_reg - 1'b1);
                    if (level_reg == '0) begin
                        q_data.ok = 1'b0;
                    end else begin
                        level_next = level_reg - 1'b1;
                        pend_next  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            parent_reg <= '0;
            pend_reg   <= 1'b0;
        end else begin
            level_reg  <= level_next;
            parent_reg <= parent_next;
            pend_reg   <= pend_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/nsta_queue.sv =====
// short command queue between front and back
`default_nettype none
module nsta_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire nsta_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output nsta_pkg::cmd_t      head,
    output logic                nonempty
);
    nsta_pkg::cmd_t mem_reg [nsta_pkg::QDEPTH];
    logic rp_reg, wp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'(nsta_pkg::QDEPTH);
    assign nonempty = cnt_reg != '0;
    assign head     = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg <= 1'b0; wp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== src/nsta_back.sv =====
// back end: anchor table, frame store, result register
`default_nettype none
module nsta_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire nsta_pkg::cmd_t head,
    input  wire logic           nonempty,
    output logic                pop,
    output logic                busy,
    output logic                pop_done,
    output logic [nsta_pkg::AW-1:0] pop_parent,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          out_status,
    output logic [63:0]         out_exc,
    output logic [63:0]         out_inc,
    output logic [31:0]         out_hits
);
    localparam int TW = 160;
    logic [TW-1:0] tab [nsta_pkg::ANCHOR_COUNT];
    logic [nsta_pkg::AW*2+127:0] frm [nsta_pkg::STACK_DEPTH];

    nsta_pkg::bstate_t st_reg, st_next;
    nsta_pkg::cmd_t    cmd_reg;
    logic [nsta_pkg::AW:0] clr_reg;
    logic [TW-1:0]     rd_reg;
    logic [nsta_pkg::AW*2+127:0] fr_reg;
    logic [63:0]       el_reg;
    logic              tab_we;
    logic [nsta_pkg::AW-1:0] tab_a;
    logic [TW-1:0]     tab_wd;
    logic [nsta_pkg::AW-1:0] fpar, fanc;
    logic [63:0]       fold, fstart;
    logic [31:0]       hnew;
    logic              ov_reg;

    assign {fpar, fanc, fold, fstart} = fr_reg;
    assign busy = st_reg == nsta_pkg::B_CLEAR;
    assign pop  = st_reg == nsta_pkg::B_IDLE && nonempty && !ov_reg;
    assign pop_done   = st_reg == nsta_pkg::B_WR_B;
    assign pop_parent = fpar;
    assign hnew = (rd_reg[31:0] == 32'hFFFF_FFFF) ? rd_reg[31:0] : rd_reg[31:0] + 32'd1;

    // exit order: read parent, write parent, read anchor, write anchor
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            nsta_pkg::B_CLEAR:
                if (clr_reg == (nsta_pkg::AW+1)'(nsta_pkg::ANCHOR_COUNT - 1))
                    st_next = nsta_pkg::B_IDLE;
            nsta_pkg::B_IDLE:
                if (pop) begin
                    if (head.ok && (head.kind == nsta_pkg::KIND_EXIT ||
                                    head.kind == nsta_pkg::KIND_ENTER ||
                                    head.kind == nsta_pkg::KIND_READ))
                        st_next = nsta_pkg::B_RD_A;
                    else st_next = nsta_pkg::B_OUT;
                end
            nsta_pkg::B_RD_A: st_next = (cmd_reg.kind == nsta_pkg::KIND_EXIT) ?
                                        nsta_pkg::B_WR_A : nsta_pkg::B_OUT;
            nsta_pkg::B_WR_A: st_next = nsta_pkg::B_RD_B;
            nsta_pkg::B_RD_B: st_next = nsta_pkg::B_WR_B;
            nsta_pkg::B_WR_B: st_next = nsta_pkg::B_OUT;
            nsta_pkg::B_OUT:  st_next = nsta_pkg::B_IDLE;
            default:          st_next = nsta_pkg::B_IDLE;
        endcase
    end

    // table port: one access a cycle
    always_comb begin
        tab_we = 1'b0;
        tab_a  = cmd_reg.anchor;
        tab_wd = '0;
        unique case (st_reg)
            nsta_pkg::B_CLEAR: begin
                tab_we = 1'b1; tab_a = clr_reg[nsta_pkg::AW-1:0];
            end
            nsta_pkg::B_RD_A:
                if (cmd_reg.kind == nsta_pkg::KIND_EXIT) tab_a = fpar;
            nsta_pkg::B_WR_A: begin
                tab_we = 1'b1; tab_a = fpar;
                tab_wd = {rd_reg[159:96] - el_reg, rd_reg[95:0]};
            end
            // anchor entry is read after the parent write, so a self parent nets to zero
            nsta_pkg::B_RD_B: tab_a = fanc;
            nsta_pkg::B_WR_B: begin
                tab_we = 1'b1; tab_a = fanc;
                tab_wd = {rd_reg[159:96] + el_reg, fold + el_reg, hnew};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tab_we) tab[tab_a] <= tab_wd;
        else rd_reg <= tab[tab_a];
    end

    // enter frame saved once the anchor's inclusive total has been read
    always_ff @(posedge aclk) begin
        if (st_reg == nsta_pkg::B_OUT && cmd_reg.ok && cmd_reg.kind == nsta_pkg::KIND_ENTER)
            frm[cmd_reg.slot] <= {cmd_reg.parent, cmd_reg.anchor, rd_reg[95:32],
                                  cmd_reg.stamp};
        fr_reg <= frm[pop ? head.slot : cmd_reg.slot];
    end

    always_ff @(posedge aclk) begin
        if (pop) cmd_reg <= head;
        if (st_reg == nsta_pkg::B_RD_A) el_reg <= cmd_reg.stamp - fstart;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= nsta_pkg::B_CLEAR; clr_reg <= '0; ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == nsta_pkg::B_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (st_reg == nsta_pkg::B_OUT) ov_reg <= 1'b1;
            else if (out_valid && out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == nsta_pkg::B_OUT) begin
            out_status <= !cmd_reg.ok ? ((cmd_reg.kind == nsta_pkg::KIND_ENTER) ?
                          nsta_pkg::ST_FULL : nsta_pkg::ST_EMPTY) : nsta_pkg::ST_OK;
            if (cmd_reg.ok && cmd_reg.kind == nsta_pkg::KIND_READ)
                {out_exc, out_inc, out_hits} <= rd_reg;
            else {out_exc, out_inc, out_hits} <= '0;
        end
    end
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ===== src/nested_scope_time_accumulator_unit.sv =====
// top level of the nested scope time accumulator
// channel | dir | handshake          | payload
// s_      | in  | s_valid / s_ready  | kind, anchor_index, timestamp
// m_      | out | m_valid / m_ready  | status, three totals
// m_valid follows B_OUT; the back end passes B_RD_A first for reads and
// enters, B_RD_A to B_WR_B for exits, neither for refused or unused kinds:
// the single-port anchor table is read and written once for parent and once
// for anchor on an exit; reset starts a clearing pass over all 4096 entries
// of the anchor table, during which s_ready stays low
// after an exit s_ready stays low until the back end restores the parent
// a waiting result holds the back end; the queue still takes beats until it is full
`default_nettype none
module nested_scope_time_accumulator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [11:0] s_anchor_index,
    input  wire logic [63:0] s_timestamp,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [63:0]      m_exclusive_total,
    output logic [63:0]      m_inclusive_total,
    output logic [31:0]      m_hit_total
);
    nsta_pkg::cmd_t qd, qh;
    logic qpush, qfull, qpop, qne, busy, pdone;
    logic [nsta_pkg::AW-1:0] ppar;

    nsta_front u_front (.aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .in_kind(s_kind), .in_anchor(s_anchor_index), .in_stamp(s_timestamp),
        .busy, .pop_done(pdone), .pop_parent(ppar), .q_data(qd), .q_push(qpush),
        .q_full(qfull));

    nsta_queue u_queue (.aclk, .aresetn, .push(qpush), .push_data(qd), .full(qfull),
        .pop(qpop), .head(qh), .nonempty(qne));

    nsta_back u_back (.aclk, .aresetn, .head(qh), .nonempty(qne), .pop(qpop),
        .busy, .pop_done(pdone), .pop_parent(ppar), .out_valid(m_valid),
        .out_ready(m_ready), .out_status(m_status), .out_exc(m_exclusive_total),
        .out_inc(m_inclusive_total), .out_hits(m_hit_total));

`ifndef SYNTH
    // no beat accepted during the clearing pass
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready) else $error("beat during clear");
    // a popped item means the queue had one
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        qpop |-> qne) else $error("pop on empty queue");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_nested_scope_time_accumulator_unit.sv =====
// self-checking testbench for the nested scope time accumulator
`default_nettype none
module tb_nested_scope_time_accumulator_unit;

    // one expected result beat
    typedef struct {
        nsta_pkg::status_t status;
        logic [63:0] excl;
        logic [63:0] incl;
        logic [31:0] hits;
    } totals_t;

    // profiler shadow plus queue of pending results
    class profile_scoreboard;
        logic [63:0] excl_tab [nsta_pkg::ANCHOR_COUNT];
        logic [63:0] incl_tab [nsta_pkg::ANCHOR_COUNT];
        logic [31:0] hit_tab  [nsta_pkg::ANCHOR_COUNT];
        logic [nsta_pkg::AW-1:0] frame_parent [nsta_pkg::STACK_DEPTH];
        logic [nsta_pkg::AW-1:0] frame_anchor [nsta_pkg::STACK_DEPTH];
        logic [63:0]   frame_incl   [nsta_pkg::STACK_DEPTH];
        logic [63:0]   frame_start  [nsta_pkg::STACK_DEPTH];
        int unsigned   depth;
        logic [nsta_pkg::AW-1:0] parent;
        totals_t       pending [$];
        int unsigned   mismatches;
        int unsigned   checked;

        function new();
            for (int i = 0; i < nsta_pkg::ANCHOR_COUNT; i++) begin
                excl_tab[i] = '0;
                incl_tab[i] = '0;
                hit_tab[i]  = '0;
            end
            depth = 0;
            parent = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void note_beat(logic [1:0] kind, logic [11:0] idx, logic [63:0] now);
            totals_t r;
            logic [63:0] dt;
            int unsigned s;
            r.status = nsta_pkg::ST_OK;
            r.excl = '0;
            r.incl = '0;
            r.hits = '0;
            if (kind == nsta_pkg::KIND_ENTER) begin
                if (depth >= nsta_pkg::STACK_DEPTH) begin
                    r.status = nsta_pkg::ST_FULL;
                end else begin
                    frame_parent[depth] = parent;
                    frame_anchor[depth] = idx;
                    frame_incl[depth]   = incl_tab[idx];
                    frame_start[depth]  = now;
                    depth++;
                    parent = idx;
                end
            end else if (kind == nsta_pkg::KIND_EXIT) begin
                if (depth == 0) begin
                    r.status = nsta_pkg::ST_EMPTY;
                end else begin
                    s = depth - 1;
                    dt = now - frame_start[s];
                    depth = s;
                    parent = frame_parent[s];
                    // parent debit first so a self-parent nets to zero
                    excl_tab[frame_parent[s]] -= dt;
                    excl_tab[frame_anchor[s]] += dt;
                    incl_tab[frame_anchor[s]] = frame_incl[s] + dt;
                    if (hit_tab[frame_anchor[s]] != 32'hFFFF_FFFF)
                        hit_tab[frame_anchor[s]] += 1;
                end
            end else if (kind == nsta_pkg::KIND_READ) begin
                r.excl = excl_tab[idx];
                r.incl = incl_tab[idx];
                r.hits = hit_tab[idx];
            end
            pending.push_back(r);
        endfunction

        function void check_beat(logic [1:0] st, logic [63:0] ex, logic [63:0] inc,
                                 logic [31:0] h);
            totals_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d", st);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || ex !== e.excl || inc !== e.incl || h !== e.hits) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch beat %0d: exp st %0d ex %h in %h hit %h, ",
                              "got st %0d ex %h in %h hit %h"},
                             checked, e.status, e.excl, e.incl, e.hits, st, ex, inc, h);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [11:0] s_anchor_index;
    logic [63:0] s_timestamp;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [63:0] m_exclusive_total;
    logic [63:0] m_inclusive_total;
    logic [31:0] m_hit_total;

    nested_scope_time_accumulator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_anchor_index(s_anchor_index), .s_timestamp(s_timestamp),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_exclusive_total(m_exclusive_total),
        .m_inclusive_total(m_inclusive_total), .m_hit_total(m_hit_total)
    );

    profile_scoreboard sb;
    int unsigned idle_cycles;
    int unsigned beats_in;
    int unsigned enters_in, exits_in, reads_in, full_seen, empty_seen;
    logic [63:0] clock_now;
    // most gaps short, a few long; sized so the watchdog never trips
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_beat(logic [1:0] kind, logic [11:0] idx, logic [63:0] now,
                             bit with_gap);
        int unsigned g;
        g = with_gap ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_anchor_index <= idx;
        s_timestamp    <= now;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: shadow model sees the beat in order
        sb.note_beat(kind, idx, now);
        beats_in++;
        case (kind)
            nsta_pkg::KIND_ENTER: enters_in++;
            nsta_pkg::KIND_EXIT:  exits_in++;
            nsta_pkg::KIND_READ:  reads_in++;
            default: ;
        endcase
    endtask

    // timestamps mostly grow, with a few wild ones for wraparound
    function automatic logic [63:0] next_stamp();
        if ($urandom_range(0, 19) == 0)
            return {$urandom, $urandom};
        clock_now += $urandom_range(1, 5000);
        return clock_now;
    endfunction

    // sink side: random stall, checked beat at each handshake edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_beat(m_status, m_exclusive_total, m_inclusive_total, m_hit_total);
                if (m_status == nsta_pkg::ST_FULL) full_seen++;
                if (m_status == nsta_pkg::ST_EMPTY) empty_seen++;
            end
            // bursts of full readiness broken up by stalls
            if ($urandom_range(0, 99) < 15)
                m_ready <= 1'b0;
            else if ($urandom_range(0, 99) < 50)
                m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", sb.pending.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned lvl;
        int unsigned n;
        logic [11:0] a;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = '0;
        s_anchor_index = '0;
        s_timestamp = '0;
        m_ready = 1'b0;
        idle_cycles = 0;
        beats_in = 0;
        enters_in = 0; exits_in = 0; reads_in = 0; full_seen = 0; empty_seen = 0;
        clock_now = 64'd1000;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: underflow on empty stack, unused kind, a read of an untouched anchor
        send_beat(nsta_pkg::KIND_EXIT, 12'd0, 64'd5, 0);
        send_beat(nsta_pkg::KIND_NONE, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_beat(nsta_pkg::KIND_READ, 12'hFFF, '0, 0);
        // self parent at root, timestamp wrap in elapsed time
        send_beat(nsta_pkg::KIND_ENTER, 12'd0, 64'hFFFF_FFFF_FFFF_FFF0, 0);
        send_beat(nsta_pkg::KIND_EXIT, 12'hABC, 64'h0000_0000_0000_0010, 0);
        send_beat(nsta_pkg::KIND_READ, 12'd0, '0, 0);
        // nested scopes with a recursive anchor; read while still open
        send_beat(nsta_pkg::KIND_ENTER, 12'd7, 64'd100, 0);
        send_beat(nsta_pkg::KIND_ENTER, 12'hFFF, 64'd150, 0);
        send_beat(nsta_pkg::KIND_ENTER, 12'd7, 64'd160, 0);
        send_beat(nsta_pkg::KIND_READ, 12'd7, '0, 0);
        send_beat(nsta_pkg::KIND_EXIT, 12'd0, 64'd200, 0);
        send_beat(nsta_pkg::KIND_EXIT, 12'd0, 64'd300, 0);
        send_beat(nsta_pkg::KIND_EXIT, 12'd0, 64'd400, 0);
        send_beat(nsta_pkg::KIND_READ, 12'd7, '0, 0);
        send_beat(nsta_pkg::KIND_READ, 12'hFFF, '0, 0);
        send_beat(nsta_pkg::KIND_READ, 12'd0, '0, 0);
        send_beat(nsta_pkg::KIND_EXIT, 12'd0, 64'd500, 0);

        // random: mostly balanced enter/exit nesting with reads, some overflow runs
        while (beats_in < 810) begin
            lvl = sb.depth;
            n = $urandom_range(0, 99);
            a = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
            if ($urandom_range(0, 199) == 0) begin
                // drive the stack past full
                repeat (nsta_pkg::STACK_DEPTH + 2 - lvl)
                    send_beat(nsta_pkg::KIND_ENTER, 12'($urandom), next_stamp(), 1);
                send_beat(nsta_pkg::KIND_READ, a, {$urandom, $urandom}, 1);
            end else if (n < 38) begin
                send_beat(nsta_pkg::KIND_ENTER, a, next_stamp(), 1);
            end else if (n < 78 || lvl > 10) begin
                send_beat(nsta_pkg::KIND_EXIT, 12'($urandom), next_stamp(), 1);
            end else if (n < 97) begin
                send_beat(nsta_pkg::KIND_READ, a, {$urandom, $urandom}, 1);
            end else begin
                send_beat(nsta_pkg::KIND_NONE, 12'($urandom), {$urandom, $urandom}, 1);
            end
        end
        // unwind and read back every anchor touched in the low range plus the top one
        while (sb.depth > 0)
            send_beat(nsta_pkg::KIND_EXIT, '0, next_stamp(), 1);
        for (int i = 0; i < 16; i++)
            send_beat(nsta_pkg::KIND_READ, 12'(i), '0, 0);
        send_beat(nsta_pkg::KIND_READ, 12'hFFF, '0, 0);
        s_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("ran %0d beats: %0d enters, %0d exits, %0d reads",
                 beats_in, enters_in, exits_in, reads_in);
        $display("%0d results checked, %0d overflow and %0d underflow refusals, %0d mismatches",
                 sb.checked, full_seen, empty_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
